### sv/frmdf_pkg.sv
// ----------------------------------------------------------------------------
// frmdf_pkg: shared types, constants and CRC helpers for the deframer
// Event codes, configuration register indexes, default geometry and the
// byte-wide CRC-8/MAXIM and CRC-16/MODBUS update functions.
// ----------------------------------------------------------------------------
package frmdf_pkg;

   // Default header geometry
   localparam int HEADER_BYTES_DEF   = 11;
   localparam int LEN_LOW_OFFSET_DEF = 6;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int POS_W  = 17;
   localparam int LEN_W  = 16;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME  = 2'd1;

   // Register reset values
   localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h00;
   localparam logic [POS_W-1:0]  MAX_FRAME_RST  = 17'd256;

   // CRC seeds and polynomials (reflected)
   localparam logic [7:0]  CRC8_INIT  = 8'h00;
   localparam logic [7:0]  CRC8_POLY  = 8'h8C;
   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [15:0] CRC16_POLY = 16'hA001;

   // Per-word event reported on the result channel
   typedef enum logic [3:0] {
      EV_STORED     = 4'd0,
      EV_DISCARD    = 4'd1,
      EV_START      = 4'd2,
      EV_HDR_OK     = 4'd3,
      EV_HDR_ERR    = 4'd4,
      EV_FRAME_OK   = 4'd5,
      EV_FRAME_ERR  = 4'd6,
      EV_OVF_END    = 4'd7,
      EV_OVF_SKIP   = 4'd8
   } event_type;

   // Next CRC values and residue flags from the CRC unit
   typedef struct packed {
      logic [7:0]  crc8;
      logic [15:0] crc16;
      logic        crc8_zero;
      logic        crc16_zero;
   } crc_next_type;

   // CRC-8/MAXIM, one byte, LSB first
   function automatic logic [7:0] crc8_maxim_byte(input logic [7:0] crc,
                                                  input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // CRC-16/MODBUS, one byte, LSB first
   function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                     input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### sv/frmdf_crc_unit.sv
// ----------------------------------------------------------------------------
// frmdf_crc_unit: byte-wide header and frame CRC update
// Advances CRC-8/MAXIM and CRC-16/MODBUS by one byte and flags zero residue.
// ----------------------------------------------------------------------------
module frmdf_crc_unit
   import frmdf_pkg::*;
(
   input  logic [7:0]   crc8_cur,
   input  logic [15:0]  crc16_cur,
   input  logic [7:0]   data_byte,
   output crc_next_type crc_next
);

   // One byte through both CRCs
   always_comb begin
      crc_next.crc8       = crc8_maxim_byte(crc8_cur, data_byte);
      crc_next.crc16      = crc16_modbus_byte(crc16_cur, data_byte);
      crc_next.crc8_zero  = (crc_next.crc8 == 8'h00);
      crc_next.crc16_zero = (crc_next.crc16 == 16'h0000);
   end

endmodule

### sv/frame_deframer_crc8_crc16_core.sv
// ----------------------------------------------------------------------------
// frame_deframer_crc8_crc16_core: start/length deframer with CRC-8 and CRC-16
// Hunts for the start byte, checks the header with CRC-8/MAXIM, reads the
// payload length and checks the whole frame with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Every received byte produces exactly one result word carrying the byte, its
// position in the frame, an in-frame flag, the header payload length and an
// event; downstream keeps a frame only if its last word reports frame ok.
// The block takes one byte per clock while the output register is empty or
// draining; the result lands there in the cycle after acceptance, with the
// byte-wide CRC and phase/position logic between state and result registers.
// Frames of total length (header + payload + 2) above max_frame_bytes are
// skipped and flagged. The user must write configuration (csr_we, csr_index,
// csr_wdata) only while no word is in flight; the block does not enforce it.
module frame_deframer_crc8_crc16_core
   import frmdf_pkg::*;
#(
   parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
   parameter int LEN_LOW_OFFSET = LEN_LOW_OFFSET_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // received bytes
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_event_res,
   output logic [BYTE_W-1:0]      rsp_byte_out,
   output logic                   rsp_in_frame,
   output logic [POS_W-1:0]       rsp_byte_pos,
   output logic [LEN_W-1:0]       rsp_payload_len
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEAD,
      PH_DATA,
      PH_SKIP
   } phase_type;

   localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] HDR_TAIL  = POS_W'(HEADER_BYTES + 2);
   localparam logic [POS_W-1:0] LEN_LO    = POS_W'(LEN_LOW_OFFSET);
   localparam logic [POS_W-1:0] LEN_HI    = POS_W'(LEN_LOW_OFFSET + 1);

   // state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [7:0]         hdr_crc_ff, hdr_crc_in;
   logic [15:0]        frm_crc_ff, frm_crc_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [BYTE_W-1:0]  start_byte_ff;
   logic [POS_W-1:0]   max_frame_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   event_type          ev_ff, ev_in;
   logic [BYTE_W-1:0]  byte_ff;
   logic               inf_ff, inf_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;

   logic               req_acc;
   logic [7:0]         crc8_cur;
   logic [15:0]        crc16_cur;
   crc_next_type       crc_next;
   logic [POS_W-1:0]   total_len;
   logic [POS_W-1:0]   frame_last;
   logic [POS_W-1:0]   total_len_next;

   // handshake: output register frees up as it drains
   assign req_ready    = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_acc      = req_valid && req_ready;
   assign rsp_valid_in = req_acc || (rsp_valid_ff && !rsp_ready);

   // CRC seed select: a new frame starts from the init values
   assign crc8_cur  = (phase_ff == PH_HUNT) ? CRC8_INIT  : hdr_crc_ff;
   assign crc16_cur = (phase_ff == PH_HUNT) ? CRC16_INIT : frm_crc_ff;

   frmdf_crc_unit u_crc (
      .crc8_cur  (crc8_cur),
      .crc16_cur (crc16_cur),
      .data_byte (req_rx_byte),
      .crc_next  (crc_next)
   );

   assign total_len  = HDR_TAIL + POS_W'(length_ff);
   assign frame_last = total_len - POS_W'(1);

   // per-byte phase logic
   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      hdr_crc_in     = hdr_crc_ff;
      frm_crc_in     = frm_crc_ff;
      length_in      = length_ff;
      total_len_next = '0;
      ev_in          = EV_STORED;
      inf_in         = 1'b0;
      pos_in         = '0;
      plen_in        = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (req_rx_byte == start_byte_ff) begin
               phase_in    = PH_HEAD;
               position_in = POS_W'(1);
               hdr_crc_in  = crc_next.crc8;
               frm_crc_in  = crc_next.crc16;
               length_in   = '0;
               ev_in       = EV_START;
               inf_in      = 1'b1;
            end else begin
               ev_in = EV_DISCARD;
            end
         end
         PH_HEAD: begin
            hdr_crc_in  = crc_next.crc8;
            frm_crc_in  = crc_next.crc16;
            if (position_ff == LEN_LO) begin
               length_in = {length_ff[15:8], req_rx_byte};
            end else if (position_ff == LEN_HI) begin
               length_in = {req_rx_byte, length_ff[7:0]};
            end
            total_len_next = HDR_TAIL + POS_W'(length_in);
            inf_in      = 1'b1;
            pos_in      = position_ff;
            position_in = position_ff + POS_W'(1);
            if (position_ff < HDR_LAST) begin
               ev_in = EV_STORED;
            end else if (crc_next.crc8_zero) begin
               // header good: decide between collecting and skipping
               ev_in    = EV_HDR_OK;
               plen_in  = length_in;
               phase_in = (total_len_next > max_frame_ff) ? PH_SKIP : PH_DATA;
            end else begin
               ev_in    = EV_HDR_ERR;
               phase_in = PH_HUNT;
            end
         end
         PH_DATA: begin
            frm_crc_in  = crc_next.crc16;
            inf_in      = 1'b1;
            pos_in      = position_ff;
            plen_in     = length_ff;
            position_in = position_ff + POS_W'(1);
            if (position_ff < frame_last) begin
               ev_in = EV_STORED;
            end else begin
               ev_in    = crc_next.crc16_zero ? EV_FRAME_OK : EV_FRAME_ERR;
               phase_in = PH_HUNT;
            end
         end
         default: begin
            // oversized frame: count the bytes through
            pos_in      = position_ff;
            plen_in     = length_ff;
            position_in = position_ff + POS_W'(1);
            if (position_ff < frame_last) begin
               ev_in = EV_OVF_SKIP;
            end else begin
               ev_in    = EV_OVF_END;
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // state, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         position_ff   <= '0;
         hdr_crc_ff    <= CRC8_INIT;
         frm_crc_ff    <= CRC16_INIT;
         length_ff     <= '0;
         start_byte_ff <= START_BYTE_RST;
         max_frame_ff  <= MAX_FRAME_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            phase_ff    <= phase_in;
            position_ff <= position_in;
            hdr_crc_ff  <= hdr_crc_in;
            frm_crc_ff  <= frm_crc_in;
            length_ff   <= length_in;
         end
         if (csr_we && csr_index == CSR_START_BYTE) begin
            start_byte_ff <= csr_wdata[BYTE_W-1:0];
         end
         if (csr_we && csr_index == CSR_MAX_FRAME) begin
            max_frame_ff <= csr_wdata[POS_W-1:0];
         end
      end
      if (req_acc) begin
         ev_ff   <= ev_in;
         byte_ff <= req_rx_byte;
         inf_ff  <= inf_in;
         pos_ff  <= pos_in;
         plen_ff <= plen_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_in_frame    = inf_ff;
   assign rsp_byte_pos    = pos_ff;
   assign rsp_payload_len = plen_ff;

   // an accepted word always lands in the output register
   a_acc_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid_ff)
      else $error("accepted word did not reach the result register");

   // a start byte while hunting opens the header at position one
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (req_acc && phase_ff == PH_HUNT && req_rx_byte == start_byte_ff)
      |=> (phase_ff == PH_HEAD && position_ff == POS_W'(1)))
      else $error("start byte did not open a header");

   // header position stays inside the header
   a_head_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEAD) |-> (position_ff >= POS_W'(1) && position_ff <= HDR_LAST))
      else $error("header position out of range");

   // payload or skip position never passes the frame's last byte
   a_body_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_SKIP) |-> (position_ff <= frame_last))
      else $error("frame position beyond frame length");

endmodule
